/* src/lrs_pkg.sv */
package lrs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W = 16;
    localparam int CODE_W = 8;
    localparam int GAIN_FRAC_BITS_DEF = 12;
    localparam int STAGES = CODE_W + 1;
    localparam int THRESH_W = 32;
    localparam int CODES = 1 << CODE_W;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    localparam int CFG_ADDR_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RED_GAIN   = 2'd0,
        REG_GREEN_GAIN = 2'd1,
        REG_BLUE_GAIN  = 2'd2
    } reg_idx_t;

    // threshold math
    localparam int WIDE_W = 448;
    localparam logic [63:0] FULL_SCALE = 64'd4294901760;
    localparam int LIN_CODES = 10;
    localparam logic [63:0] LIN_DEN = 64'd32946;
    localparam logic [31:0] POW_NUM_STEP = 32'd400;
    localparam logic [31:0] POW_NUM_BASE = 32'd5410;
    localparam logic [31:0] POW_DEN = 32'd107610;

    typedef logic [WIDE_W-1:0] wide_t;
    typedef logic [THRESH_W-1:0] thresh_arr_t [CODES];

    // smallest q per code k with q >= linear level of half code (k - 0.5)
    function automatic thresh_arr_t build_thresh();
        thresh_arr_t t;
        wide_t den12;
        wide_t rhs;
        wide_t lhs;
        logic [63:0] num;
        logic [31:0] a;
        logic [32:0] lo;
        logic [32:0] hi;
        logic [32:0] mid;
        t[0] = '0;
        for (int k = 1; k <= LIN_CODES; k++)
        begin
            num = 64'(5 * (2 * k - 1)) * FULL_SCALE;
            t[k] = THRESH_W'((num + LIN_DEN - 64'd1) / LIN_DEN);
        end
        den12 = WIDE_W'(1);
        for (int i = 0; i < 12; i++)
        begin
            den12 = den12 * WIDE_W'(POW_DEN);
        end
        for (int k = LIN_CODES + 1; k < CODES; k++)
        begin
            a = POW_NUM_STEP * 32'(k) + POW_NUM_BASE;
            rhs = WIDE_W'(1);
            for (int i = 0; i < 12; i++)
            begin
                rhs = rhs * WIDE_W'(a);
            end
            for (int i = 0; i < 5; i++)
            begin
                rhs = rhs * WIDE_W'(FULL_SCALE);
            end
            lo = '0;
            hi = 33'(FULL_SCALE);
            for (int s = 0; s < 34; s++)
            begin
                if (lo < hi)
                begin
                    mid = lo + ((hi - lo) >> 1);
                    lhs = den12;
                    for (int i = 0; i < 5; i++)
                    begin
                        lhs = lhs * WIDE_W'(mid);
                    end
                    if (lhs >= rhs)
                    begin
                        hi = mid;
                    end
                    else
                    begin
                        lo = mid + 33'd1;
                    end
                end
            end
            t[k] = lo[THRESH_W-1:0];
        end
        return t;
    endfunction

    localparam thresh_arr_t THRESH = build_thresh();

endpackage

/* src/lrs_channel.sv */
module lrs_channel
    import lrs_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic [STAGES-1:0]   en,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [GAIN_W-1:0]   gain,
    output logic [CODE_W-1:0]   code
);

    localparam int GEFF_W = GAIN_W + 1;
    localparam int PROD_W = SAMPLE_W + GEFF_W;
    localparam int SHIFT = SAMPLE_W - GAIN_FRAC_BITS;
    localparam int Q_W = PROD_W + SHIFT;

    logic [GEFF_W-1:0] gain_eff;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    q_next;
    logic [Q_W-1:0]    q_reg [STAGES-1];
    logic [CODE_W-1:0] code_reg [STAGES];
    logic [CODE_W-1:0] cand_code [STAGES];
    logic [CODE_W-1:0] code_next [STAGES];

    // zero gain means unity
    always_comb
    begin
        if (gain == '0)
        begin
            gain_eff = GEFF_W'(1) << GAIN_FRAC_BITS;
        end
        else
        begin
            gain_eff = {1'b0, gain};
        end
        prod = PROD_W'(sample) * PROD_W'(gain_eff);
        q_next = Q_W'(prod) << SHIFT;
    end

    // binary search over the threshold table, one code bit per stage
    always_comb
    begin
        cand_code[0] = '0;
        code_next[0] = '0;
        for (int i = 1; i < STAGES; i++)
        begin
            cand_code[i] = code_reg[i-1] | (CODE_W'(1) << (CODE_W - i));
            if (q_reg[i-1] >= Q_W'(THRESH[cand_code[i]]))
            begin
                code_next[i] = cand_code[i];
            end
            else
            begin
                code_next[i] = code_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            q_reg[0] <= q_next;
            code_reg[0] <= code_next[0];
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (en[i])
            begin
                code_reg[i] <= code_next[i];
            end
        end
        for (int i = 1; i < STAGES - 1; i++)
        begin
            if (en[i])
            begin
                q_reg[i] <= q_reg[i-1];
            end
        end
    end

    assign code = code_reg[STAGES-1];

endmodule

/* src/linear_rgb_to_srgb8_preview.sv */
// White-balanced linear RGB (16 bits per channel, 65535 = 1.0) to 8-bit sRGB codes,
// rounded to nearest. Each channel is multiplied by its Q4.12 gain (zero acts as unity),
// clamped at full scale and encoded with the sRGB curve by searching a 256-entry
// threshold table. One pixel is taken every clock unless the output stalls; it passes
// one multiply stage and then eight search stages, one code bit each. Back-pressure on
// the output stalls only the stages that are full, so bubbles are squeezed out. Gains
// are written via the cfg port only while idle; the user ensures it, not the block.
module linear_rgb_to_srgb8_preview
    import lrs_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [GAIN_W-1:0]       cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [3*SAMPLE_W-1:0]   s_tdata,    // red_linear, green_linear, blue_linear
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [3*CODE_W-1:0]     m_tdata     // red_code, green_code, blue_code
);

    logic [GAIN_W-1:0] red_gain_reg;
    logic [GAIN_W-1:0] green_gain_reg;
    logic [GAIN_W-1:0] blue_gain_reg;
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_gain_reg <= GAIN_RESET;
            green_gain_reg <= GAIN_RESET;
            blue_gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_RED_GAIN:   red_gain_reg <= cfg_wdata;
                REG_GREEN_GAIN: green_gain_reg <= cfg_wdata;
                REG_BLUE_GAIN:  blue_gain_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // a stage moves when it is empty or the next one moves
    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[0] = adv[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[STAGES-1];

    lrs_channel #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_red (
        .clk    (clk),
        .en     (adv),
        .sample (s_tdata[SAMPLE_W-1:0]),
        .gain   (red_gain_reg),
        .code   (m_tdata[CODE_W-1:0])
    );

    lrs_channel #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_green (
        .clk    (clk),
        .en     (adv),
        .sample (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .gain   (green_gain_reg),
        .code   (m_tdata[2*CODE_W-1:CODE_W])
    );

    lrs_channel #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_blue (
        .clk    (clk),
        .en     (adv),
        .sample (s_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
        .gain   (blue_gain_reg),
        .code   (m_tdata[3*CODE_W-1:2*CODE_W])
    );

    a_ready_when_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!valid_reg[STAGES-1] || m_tready) |-> s_tready)
        else $error("input stalled while output stage drains");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted beat lost at first stage");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (valid_reg == {STAGES{1'b1}}))
        else $error("input stalled with a bubble in the pipeline");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output beat changed");

endmodule

/* tb/srgb_code_checker.sv */
`timescale 1ns / 1ps

module srgb_code_checker
    import lrs_pkg::*;
#(
    parameter int FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [GAIN_W-1:0]       cfg_wdata,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [3*SAMPLE_W-1:0]   s_tdata,    // red_linear, green_linear, blue_linear
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [3*CODE_W-1:0]     m_tdata,    // red_code, green_code, blue_code
    output int                      mismatches,
    output int                      outstanding,
    output int                      checked
);

    localparam logic [63:0] WHITE_Q = 64'd4294901760;
    localparam int SEGMENT_CODES = 10;
    localparam logic [63:0] SEGMENT_DEN = 64'd32946;
    localparam logic [31:0] CURVE_STEP = 32'd400;
    localparam logic [31:0] CURVE_BASE = 32'd5410;
    localparam logic [31:0] CURVE_DEN = 32'd107610;

    typedef struct packed {
        logic [CODE_W-1:0] blue;
        logic [CODE_W-1:0] green;
        logic [CODE_W-1:0] red;
    } pixel_codes_t;

    logic [63:0] half_code_level [CODES];
    logic [GAIN_W-1:0] red_gain;
    logic [GAIN_W-1:0] green_gain;
    logic [GAIN_W-1:0] blue_gain;
    pixel_codes_t expected_codes [$];

    // true when q^5 * den^12 >= a^12 * white^5, i.e. q reaches the curve level
    function automatic bit curve_reached(logic [31:0] a, logic [63:0] q);
        logic [511:0] lhs;
        logic [511:0] rhs;
        lhs = 512'd1;
        rhs = 512'd1;
        for (int i = 0; i < 12; i++)
        begin
            lhs = lhs * 512'(CURVE_DEN);
            rhs = rhs * 512'(a);
        end
        for (int i = 0; i < 5; i++)
        begin
            lhs = lhs * 512'(q);
            rhs = rhs * 512'(WHITE_Q);
        end
        return lhs >= rhs;
    endfunction

    initial
    begin
        real estimate;
        logic [31:0] a;
        logic [63:0] q;
        half_code_level[0] = '0;
        for (int k = 1; k <= SEGMENT_CODES; k++)
        begin
            q = 64'(5 * (2 * k - 1)) * WHITE_Q;
            half_code_level[k] = (q + SEGMENT_DEN - 64'd1) / SEGMENT_DEN;
        end
        // float guess, then exact integer correction to the smallest q
        for (int k = SEGMENT_CODES + 1; k < CODES; k++)
        begin
            a = CURVE_STEP * 32'(k) + CURVE_BASE;
            estimate = $pow(real'(a) / real'(CURVE_DEN), 2.4) * 4294901760.0;
            q = 64'(longint'(estimate));
            while (q > 0 && curve_reached(a, q - 64'd1))
            begin
                q = q - 64'd1;
            end
            while (!curve_reached(a, q))
            begin
                q = q + 64'd1;
            end
            half_code_level[k] = q;
        end
    end

    function automatic logic [CODE_W-1:0] encode_code(logic [SAMPLE_W-1:0] sample,
                                                      logic [GAIN_W-1:0] gain);
        logic [63:0] gain_eff;
        logic [63:0] q;
        int n;
        gain_eff = (gain == '0) ? (64'd1 << FRAC_BITS) : 64'(gain);
        q = (64'(sample) * gain_eff) << (16 - FRAC_BITS);
        n = 0;
        for (int k = 1; k < CODES; k++)
        begin
            if (q >= half_code_level[k])
            begin
                n++;
            end
        end
        return CODE_W'(n);
    endfunction

    function automatic int field_wrong(string field, logic [CODE_W-1:0] want,
                                       logic [CODE_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_codes_t want;
        pixel_codes_t got;
        int bad;
        if (!rst_n)
        begin
            red_gain <= GAIN_RESET;
            green_gain <= GAIN_RESET;
            blue_gain <= GAIN_RESET;
            expected_codes.delete();
            mismatches <= 0;
            outstanding <= 0;
            checked <= 0;
        end
        else
        begin
            bad = 0;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_RED_GAIN:   red_gain <= cfg_wdata;
                    REG_GREEN_GAIN: green_gain <= cfg_wdata;
                    REG_BLUE_GAIN:  blue_gain <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_codes.size() == 0)
                begin
                    $error("result beat %h with no pixel pending", m_tdata);
                    bad++;
                end
                else
                begin
                    want = expected_codes.pop_front();
                    bad += field_wrong("red_code", want.red, got.red);
                    bad += field_wrong("green_code", want.green, got.green);
                    bad += field_wrong("blue_code", want.blue, got.blue);
                    checked <= checked + 1;
                end
            end
            if (s_tvalid && s_tready)
            begin
                want.red = encode_code(s_tdata[SAMPLE_W-1:0], red_gain);
                want.green = encode_code(s_tdata[2*SAMPLE_W-1:SAMPLE_W], green_gain);
                want.blue = encode_code(s_tdata[3*SAMPLE_W-1:2*SAMPLE_W], blue_gain);
                expected_codes.push_back(want);
            end
            mismatches <= mismatches + bad;
            outstanding <= expected_codes.size();
        end
    end

endmodule

/* tb/linear_rgb_to_srgb8_preview_tb.sv */
`timescale 1ns / 1ps

module linear_rgb_to_srgb8_preview_tb;
    import lrs_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES = 8;
    localparam int PHASE_PIXELS = 110;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [GAIN_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [3*SAMPLE_W-1:0]  s_tdata = '0;   // red_linear, green_linear, blue_linear
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [3*CODE_W-1:0]    m_tdata;        // red_code, green_code, blue_code

    int mismatches;
    int outstanding;
    int checked;
    int pixels_sent = 0;
    int gain_settings = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    linear_rgb_to_srgb8_preview dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    srgb_code_checker code_check (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .mismatches(mismatches),
        .outstanding(outstanding),
        .checked(checked)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(9) == 0)
        begin
            return $urandom_range(8, 30);
        end
        return $urandom_range(1, 3);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(99) < stall_pct)
        begin
            stall_left = gap_length() - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // sample that lands on the half-code level of code k under this gain, plus offset
    function automatic logic [SAMPLE_W-1:0] near_half_code(int k, logic [GAIN_W-1:0] gain,
                                                           int offset);
        real x;
        real gain_eff;
        longint s;
        gain_eff = (gain == '0) ? real'(1 << GAIN_FRAC_BITS_DEF) : real'(gain);
        if (k <= 10)
        begin
            x = real'((2 * k - 1) * 5) / 32946.0;
        end
        else
        begin
            x = $pow((400.0 * k + 5410.0) / 107610.0, 2.4);
        end
        s = longint'($floor(x * 65535.0 * real'(1 << GAIN_FRAC_BITS_DEF) / gain_eff));
        s = s + offset;
        if (s < 0)
        begin
            s = 0;
        end
        if (s > 65535)
        begin
            s = 65535;
        end
        return SAMPLE_W'(s);
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample(logic [GAIN_W-1:0] gain);
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            return SAMPLE_W'($urandom);
        end
        if (pick < 85)
        begin
            return near_half_code($urandom_range(1, 255), gain, $urandom_range(0, 4) - 2);
        end
        if (pick < 92)
        begin
            return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        return SAMPLE_W'($urandom_range(0, 300));
    endfunction

    task automatic send_pixel(input logic [SAMPLE_W-1:0] red, input logic [SAMPLE_W-1:0] green,
                              input logic [SAMPLE_W-1:0] blue);
        int gap;
        gap = ($urandom_range(99) < gap_pct) ? gap_length() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {blue, green, red};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pixels_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // the write to the unused index must leave all gains alone
    task automatic program_gains(input logic [GAIN_W-1:0] red, input logic [GAIN_W-1:0] green,
                                 input logic [GAIN_W-1:0] blue);
        cfg_we <= 1'b1;
        cfg_addr <= REG_RED_GAIN;
        cfg_wdata <= red;
        @(posedge clk);
        cfg_addr <= REG_GREEN_GAIN;
        cfg_wdata <= green;
        @(posedge clk);
        cfg_addr <= REG_BLUE_GAIN;
        cfg_wdata <= blue;
        @(posedge clk);
        cfg_addr <= REG_UNUSED;
        cfg_wdata <= GAIN_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        gain_settings++;
    endtask

    initial
    begin
        logic [GAIN_W-1:0] red_gain;
        logic [GAIN_W-1:0] green_gain;
        logic [GAIN_W-1:0] blue_gain;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains are unity
        gap_pct = 10;
        stall_pct = 10;
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'hFFFF);
        send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
        send_pixel(16'h5555, 16'hAAAA, 16'h5555);
        send_pixel(16'd1, 16'd2, 16'd3);
        // both sides of the half-code levels, across the segment to power-law knee
        for (int off = -1; off <= 1; off++)
        begin
            send_pixel(near_half_code(1, GAIN_RESET, off), near_half_code(10, GAIN_RESET, off),
                       near_half_code(11, GAIN_RESET, off));
            send_pixel(near_half_code(128, GAIN_RESET, off),
                       near_half_code(254, GAIN_RESET, off),
                       near_half_code(255, GAIN_RESET, off));
        end
        drain();

        // zero gain acts as unity
        program_gains(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(near_half_code(200, GAIN_RESET, 0), near_half_code(200, GAIN_RESET, 1),
                   near_half_code(11, GAIN_RESET, 0));
        send_pixel(16'd1000, 16'd30000, 16'd50000);
        drain();

        // largest gain, products clamp at white
        program_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'd1, 16'd1, 16'd1);
        send_pixel(16'd4096, 16'd4095, 16'd4097);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();

        program_gains(16'h0001, 16'h0001, 16'h0001);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'd1, 16'd1, 16'd1);
        send_pixel(16'd12345, 16'd54321, 16'd65534);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    red_gain = GAIN_W'($urandom_range(2048, 8192));
                    green_gain = GAIN_W'($urandom_range(2048, 8192));
                    blue_gain = GAIN_W'($urandom_range(2048, 8192));
                end
                1:
                begin
                    red_gain = 16'hFFFF;
                    green_gain = 16'hFFFF;
                    blue_gain = 16'hFFFF;
                end
                2:
                begin
                    red_gain = 16'h0001;
                    green_gain = 16'h0001;
                    blue_gain = 16'h0001;
                end
                3:
                begin
                    red_gain = 16'h0000;
                    green_gain = 16'hFFFF;
                    blue_gain = GAIN_W'($urandom_range(4096, 12288));
                end
                default:
                begin
                    red_gain = GAIN_W'($urandom);
                    green_gain = GAIN_W'($urandom);
                    blue_gain = GAIN_W'($urandom);
                end
            endcase
            program_gains(red_gain, green_gain, blue_gain);
            gap_pct = (p == 4) ? 0 : (p % 4) * 25;
            stall_pct = (p == 4) ? 0 : ((p + 2) % 4) * 25;
            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                send_pixel(random_sample(red_gain), random_sample(green_gain),
                           random_sample(blue_gain));
            end
            drain();
        end

        repeat (20) @(posedge clk);
        $display("tb: %0d pixels sent, %0d results checked under %0d gain settings",
                 pixels_sent, checked, gain_settings);
        $display("tb: gains covered zero, one, unity and maximum, with samples near code levels");
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* linear_rgb_to_srgb8_preview.f */
src/lrs_pkg.sv
src/lrs_channel.sv
src/linear_rgb_to_srgb8_preview.sv
tb/srgb_code_checker.sv
tb/linear_rgb_to_srgb8_preview_tb.sv
